@@ rtl/pn3d_pkg.sv @@
// Package for the 3D gradient noise block: permutation table, gradient
// select function, fixed-point widths and parameter defaults.
// Depends on nothing; used by perlin_noise_3d.
`default_nettype none

package pn3d_pkg;

    localparam int QB                  = 16;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF   = 14;
    localparam int COORD_W             = 32;
    localparam int NOISE_W             = 16;

    // Corner offset (Q.16, one sign bit above the unit), gradient sum,
    // blend value, fade weight.
    localparam int OFS_W  = QB + 2;
    localparam int GRAD_W = QB + 3;
    localparam int LRP_W  = QB + 4;
    localparam int FADE_W = QB + 1;

    typedef logic [7:0] byte_t;

    localparam byte_t PERM_TAB [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Picks two of the three offsets by the low hash nibble and adds them
    // with signs; four of the sixteen codes repeat earlier gradients.
    function automatic logic signed [GRAD_W-1:0] grad_sum(
        input logic [3:0]              k,
        input logic signed [OFS_W-1:0] x,
        input logic signed [OFS_W-1:0] y,
        input logic signed [OFS_W-1:0] z
    );
        logic signed [GRAD_W-1:0] a;
        logic signed [GRAD_W-1:0] b;
        if (k < 4'd8)
            a = GRAD_W'(x);
        else
            a = GRAD_W'(y);
        if (k < 4'd4)
            b = GRAD_W'(y);
        else if (k == 4'd12 || k == 4'd14)
            b = GRAD_W'(x);
        else
            b = GRAD_W'(z);
        if (k[0])
            a = -a;
        if (k[1])
            b = -b;
        return a + b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/perlin_noise_3d.sv @@
// Top level of the 3D gradient noise evaluator: ten-stage pipeline from
// coordinates to a saturated noise sample. Depends on pn3d_pkg.
//
//  Channel   Valid        Ready        Payload
//  coord     coord_valid  coord_ready  coord_x, coord_y, coord_z
//  noise     noise_valid  noise_ready  noise_value
//
// One point enters per cycle while coord_ready is high; a noise-side stall can
// drop coord_ready. The depth is set by the chain hash (three table levels), fade
// multiplies and three blend levels, each multiply and add in its own stage.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall on the noise side fills bubbles first, so a stage only holds when
// the stage after it is occupied and holding.
`default_nettype none

module perlin_noise_3d #(
    parameter int COORD_FRAC_BITS = pn3d_pkg::COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = pn3d_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  coord_valid,
    output logic                                       coord_ready,
    input  wire logic signed [pn3d_pkg::COORD_W-1:0]   coord_x,
    input  wire logic signed [pn3d_pkg::COORD_W-1:0]   coord_y,
    input  wire logic signed [pn3d_pkg::COORD_W-1:0]   coord_z,
    output logic                                       noise_valid,
    input  wire logic                                  noise_ready,
    output logic signed [pn3d_pkg::NOISE_W-1:0]        noise_value
);

    localparam int QB     = pn3d_pkg::QB;
    localparam int OFS_W  = pn3d_pkg::OFS_W;
    localparam int GRAD_W = pn3d_pkg::GRAD_W;
    localparam int LRP_W  = pn3d_pkg::LRP_W;
    localparam int FADE_W = pn3d_pkg::FADE_W;
    localparam int NST    = 10;
    localparam int SH     = QB - OUT_FRAC_BITS;
    localparam int PRD_W  = LRP_W + 1 + FADE_W + 1;
    localparam int QF_W   = 2 * QB + 5;
    localparam int Q_W    = QF_W - QB;
    localparam int FP_W   = Q_W + QB;

    // Stage valid bits and advance enables.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || noise_ready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign coord_ready = en[0];
    assign noise_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= coord_valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // ---------------- Stage 1: split, first hash level, t squared
    logic [pn3d_pkg::COORD_W-1:0] coord_arr [3];
    logic [7:0]                   cell_next [3];
    logic [QB-1:0]                frac_next [3];

    assign coord_arr[0] = coord_x;
    assign coord_arr[1] = coord_y;
    assign coord_arr[2] = coord_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_split
        assign cell_next[i] = coord_arr[i][COORD_FRAC_BITS +: 8];
        if (COORD_FRAC_BITS >= QB)
        begin : g_trunc
            assign frac_next[i] = coord_arr[i][COORD_FRAC_BITS-1 -: QB];
        end
        else
        begin : g_pad
            assign frac_next[i] = {coord_arr[i][COORD_FRAC_BITS-1:0],
                                   {(QB - COORD_FRAC_BITS){1'b0}}};
        end
    end

    logic [7:0]      cell_s1_reg [3];
    logic [QB-1:0]   frac_s1_reg [3];
    logic [2*QB-1:0] t2_s1_reg   [3];
    logic [7:0]      hx_s1_reg   [2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                cell_s1_reg[i] <= cell_next[i];
                frac_s1_reg[i] <= frac_next[i];
                t2_s1_reg[i]   <= (2*QB)'(frac_next[i]) * (2*QB)'(frac_next[i]);
            end
            for (int d = 0; d < 2; d++)
                hx_s1_reg[d] <= pn3d_pkg::PERM_TAB[cell_next[0] + 8'(d)];
        end
    end

    // ---------------- Stage 2: second hash level, fade polynomial, t cubed
    logic [7:0]    zi_s2_reg;
    logic [QB-1:0] frac_s2_reg [3];
    logic [Q_W-1:0] q_s2_reg   [3];
    logic [QB-1:0] t3_s2_reg   [3];
    logic [7:0]    hxy_s2_reg  [4];
    logic [QF_W-1:0] qfull_next [3];
    logic [2*QB-1:0] t3full_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qfull_next[i] = QF_W'(t2_s1_reg[i]) * QF_W'(6)
                          + (QF_W'(10) << (2 * QB))
                          - ((QF_W'(frac_s1_reg[i]) * QF_W'(15)) << QB);
            t3full_next[i] = (2*QB)'(t2_s1_reg[i][2*QB-1:QB])
                           * (2*QB)'(frac_s1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            zi_s2_reg <= cell_s1_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                frac_s2_reg[i] <= frac_s1_reg[i];
                q_s2_reg[i]    <= qfull_next[i][QF_W-1:QB];
                t3_s2_reg[i]   <= t3full_next[i][2*QB-1:QB];
            end
            for (int d = 0; d < 4; d++)
                hxy_s2_reg[d] <= pn3d_pkg::PERM_TAB[hx_s1_reg[d % 2]
                                 + cell_s1_reg[1] + 8'(d / 2)];
        end
    end

    // ---------------- Stage 3: corner hashes, fade product
    logic [QB-1:0]     frac_s3_reg [3];
    logic [FADE_W-1:0] fade_s3_reg [3];
    logic [7:0]        hash_s3_reg [8];
    logic [FP_W-1:0]   fprod_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            fprod_next[i] = FP_W'(q_s2_reg[i]) * FP_W'(t3_s2_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                frac_s3_reg[i] <= frac_s2_reg[i];
                fade_s3_reg[i] <= fprod_next[i][QB +: FADE_W];
            end
            for (int c = 0; c < 8; c++)
                hash_s3_reg[c] <= pn3d_pkg::PERM_TAB[hxy_s2_reg[c % 4]
                                  + zi_s2_reg + 8'(c / 4)];
        end
    end

    // ---------------- Stage 4: gradient sums at the eight corners
    logic signed [GRAD_W-1:0] grad_s4_reg [8];
    logic [FADE_W-1:0]        fade_s4_reg [3];
    logic signed [OFS_W-1:0]  ofs_lo [3];
    logic signed [OFS_W-1:0]  ofs_hi [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ofs_lo[i] = {2'b00, frac_s3_reg[i]};
            ofs_hi[i] = {2'b11, frac_s3_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
                fade_s4_reg[i] <= fade_s3_reg[i];
            for (int c = 0; c < 8; c++)
                grad_s4_reg[c] <= pn3d_pkg::grad_sum(hash_s3_reg[c][3:0],
                    c[0] ? ofs_hi[0] : ofs_lo[0],
                    c[1] ? ofs_hi[1] : ofs_lo[1],
                    c[2] ? ofs_hi[2] : ofs_lo[2]);
        end
    end

    // ---------------- Stages 5 to 10: three blend levels
    logic signed [PRD_W-1:0]  px_s5_reg [4];
    logic signed [LRP_W-1:0]  ax_s5_reg [4];
    logic [FADE_W-1:0]        v_s5_reg;
    logic [FADE_W-1:0]        w_s5_reg;
    logic signed [LRP_W-1:0]  lx_s6_reg [4];
    logic [FADE_W-1:0]        v_s6_reg;
    logic [FADE_W-1:0]        w_s6_reg;
    logic signed [PRD_W-1:0]  py_s7_reg [2];
    logic signed [LRP_W-1:0]  ay_s7_reg [2];
    logic [FADE_W-1:0]        w_s7_reg;
    logic signed [LRP_W-1:0]  ly_s8_reg [2];
    logic [FADE_W-1:0]        w_s8_reg;
    logic signed [PRD_W-1:0]  pz_s9_reg;
    logic signed [LRP_W-1:0]  az_s9_reg;
    logic signed [pn3d_pkg::NOISE_W-1:0] noise_reg;

    logic signed [FADE_W:0]   wu_s4;
    logic signed [FADE_W:0]   wv_s6;
    logic signed [FADE_W:0]   wz_s8;
    logic signed [LRP_W:0]    dx_s4 [4];
    logic signed [LRP_W:0]    dy_s6 [2];
    logic signed [LRP_W:0]    dz_s8;
    logic signed [LRP_W-1:0]  e_s9;
    logic signed [LRP_W-1:0]  r_s9;
    logic signed [pn3d_pkg::NOISE_W-1:0] noise_next;

    always_comb
    begin
        wu_s4 = {1'b0, fade_s4_reg[0]};
        wv_s6 = {1'b0, v_s6_reg};
        wz_s8 = {1'b0, w_s8_reg};
        for (int p = 0; p < 4; p++)
            dx_s4[p] = (LRP_W+1)'(grad_s4_reg[2*p+1]) - (LRP_W+1)'(grad_s4_reg[2*p]);
        for (int p = 0; p < 2; p++)
            dy_s6[p] = (LRP_W+1)'(lx_s6_reg[2*p+1]) - (LRP_W+1)'(lx_s6_reg[2*p]);
        dz_s8 = (LRP_W+1)'(ly_s8_reg[1]) - (LRP_W+1)'(ly_s8_reg[0]);
        // Arithmetic shifts floor toward minus infinity, as the blend needs.
        e_s9 = az_s9_reg + pz_s9_reg[QB +: LRP_W];
        r_s9 = e_s9 >>> SH;
        if (r_s9 > LRP_W'(32767))
            noise_next = 16'sh7FFF;
        else if (r_s9 < -LRP_W'(32768))
            noise_next = 16'sh8000;
        else
            noise_next = r_s9[pn3d_pkg::NOISE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int p = 0; p < 4; p++)
            begin
                px_s5_reg[p] <= PRD_W'(dx_s4[p]) * PRD_W'(wu_s4);
                ax_s5_reg[p] <= LRP_W'(grad_s4_reg[2*p]);
            end
            v_s5_reg <= fade_s4_reg[1];
            w_s5_reg <= fade_s4_reg[2];
        end
        if (en[5])
        begin
            for (int p = 0; p < 4; p++)
                lx_s6_reg[p] <= ax_s5_reg[p] + px_s5_reg[p][QB +: LRP_W];
            v_s6_reg <= v_s5_reg;
            w_s6_reg <= w_s5_reg;
        end
        if (en[6])
        begin
            for (int p = 0; p < 2; p++)
            begin
                py_s7_reg[p] <= PRD_W'(dy_s6[p]) * PRD_W'(wv_s6);
                ay_s7_reg[p] <= lx_s6_reg[2*p];
            end
            w_s7_reg <= w_s6_reg;
        end
        if (en[7])
        begin
            for (int p = 0; p < 2; p++)
                ly_s8_reg[p] <= ay_s7_reg[p] + py_s7_reg[p][QB +: LRP_W];
            w_s8_reg <= w_s7_reg;
        end
        if (en[8])
        begin
            pz_s9_reg <= PRD_W'(dz_s8) * PRD_W'(wz_s8);
            az_s9_reg <= ly_s8_reg[0];
        end
        if (en[9])
            noise_reg <= noise_next;
    end

    assign noise_value = noise_reg;

    // A held input side means the first stage is occupied.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !coord_ready |-> valid_reg[0])
        else $error("coord_ready low with empty first stage");

    // Fade weights never exceed one in Q.16.
    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (fade_s3_reg[0] <= FADE_W'(65536)
                          && fade_s3_reg[1] <= FADE_W'(65536)
                          && fade_s3_reg[2] <= FADE_W'(65536)))
        else $error("fade weight above one");

    // An occupied gradient stage that advances lands in the first blend stage.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && en[4] |=> valid_reg[4])
        else $error("transaction lost between gradient and blend stages");

endmodule

`default_nettype wire

@@ dv/perlin_noise_3d_checker.sv @@
// Checker for the 3D gradient noise block: watches both channels, predicts
// each noise sample from the accepted coordinates and compares in order.
// Depends on pn3d_pkg for widths and the permutation table.
module perlin_noise_3d_checker #(
    parameter int COORD_FRAC_BITS = pn3d_pkg::COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = pn3d_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  coord_valid,
    input  logic                                  coord_ready,
    input  logic signed [pn3d_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [pn3d_pkg::COORD_W-1:0]   coord_y,
    input  logic signed [pn3d_pkg::COORD_W-1:0]   coord_z,
    input  logic                                  noise_valid,
    input  logic                                  noise_ready,
    input  logic signed [pn3d_pkg::NOISE_W-1:0]   noise_value,
    output int                                    fail_count,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT = 64'sd65536;

    logic signed [15:0] noise_q[$];

    function automatic longint floor_div(longint v, int k);
        return v >>> k;
    endfunction

    function automatic int hash8(int i);
        return int'(pn3d_pkg::PERM_TAB[i & 8'hFF]);
    endfunction

    function automatic longint fade_q16(longint t);
        longint t2, q, t3;
        t2 = t * t;
        q = (6 * t2 + (longint'(10) << 32) - ((15 * t) << 16)) >>> 16;
        t3 = ((t2 >>> 16) * t) >>> 16;
        return (q * t3) >>> 16;
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + floor_div((b - a) * w, 16);
    endfunction

    function automatic longint grad_dot(int h, longint x, longint y, longint z);
        int k;
        longint a, b;
        k = h & 15;
        a = (k < 8) ? x : y;
        b = (k < 4) ? y : ((k == 12 || k == 14) ? x : z);
        return (k[0] ? -a : a) + (k[1] ? -b : b);
    endfunction

    function automatic longint frac_q16(logic [31:0] c);
        longint f;
        f = longint'(c) & ((longint'(1) << COORD_FRAC_BITS) - 1);
        if (COORD_FRAC_BITS >= 16)
            return f >> (COORD_FRAC_BITS - 16);
        return f << (16 - COORD_FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] noise_at(logic [31:0] cx, logic [31:0] cy,
                                                    logic [31:0] cz);
        int xi, yi, zi;
        longint fx[2], fy[2], fz[2], u, v, w, lo[2], r;
        longint g[8];
        xi = int'((cx >> COORD_FRAC_BITS) & 32'hFF);
        yi = int'((cy >> COORD_FRAC_BITS) & 32'hFF);
        zi = int'((cz >> COORD_FRAC_BITS) & 32'hFF);
        fx[0] = frac_q16(cx);
        fy[0] = frac_q16(cy);
        fz[0] = frac_q16(cz);
        fx[1] = fx[0] - UNIT;
        fy[1] = fy[0] - UNIT;
        fz[1] = fz[0] - UNIT;
        u = fade_q16(fx[0]);
        v = fade_q16(fy[0]);
        w = fade_q16(fz[0]);
        // Corner index bit 0 is x, bit 1 is y, bit 2 is z.
        for (int n = 0; n < 8; n++)
            g[n] = grad_dot(hash8(hash8(hash8(xi + n[0]) + yi + n[1]) + zi + n[2]),
                            fx[n[0]], fy[n[1]], fz[n[2]]);
        for (int s = 0; s < 2; s++)
            lo[s] = blend(blend(g[4*s], g[4*s+1], u), blend(g[4*s+2], g[4*s+3], u), v);
        r = floor_div(blend(lo[0], lo[1], w), 16 - OUT_FRAC_BITS);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    assign pending = noise_q.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        logic signed [15:0] want;
        if (rst_n)
        begin
            if (coord_valid && coord_ready)
                noise_q = {noise_q, noise_at(coord_x, coord_y, coord_z)};
            if (noise_valid && noise_ready)
            begin
                if (noise_q.size() == 0)
                begin
                    $display("%0t: unexpected noise transaction, actual %0d", $time,
                             noise_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = noise_q.pop_front();
                    if (want !== noise_value)
                    begin
                        $display("%0t: noise_value expected %0d actual %0d", $time,
                                 want, noise_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ dv/tb_perlin_noise_3d.sv @@
// Top of the noise block testbench: clock, reset, coordinate stimulus and
// result-side stalls. Depends on perlin_noise_3d and its checker.
module tb_perlin_noise_3d;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        coord_valid = 1'b0;
    logic        coord_ready;
    logic [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic        noise_valid;
    logic        noise_ready = 1'b0;
    logic [15:0] noise_value;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          quiet_sink = 1'b0;

    always #5 clk = ~clk;

    perlin_noise_3d dut (
        .clk(clk), .rst_n(rst_n),
        .coord_valid(coord_valid), .coord_ready(coord_ready),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .noise_valid(noise_valid), .noise_ready(noise_ready),
        .noise_value(noise_value)
    );

    perlin_noise_3d_checker chk (
        .clk(clk), .rst_n(rst_n),
        .coord_valid(coord_valid), .coord_ready(coord_ready),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .noise_valid(noise_valid), .noise_ready(noise_ready),
        .noise_value(noise_value),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // A coordinate near a cell edge, in a random cell, or fully random bits.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))};
            2: return {16'($urandom_range(0, 65535)),
                       16'hFFFF - 16'($urandom_range(0, 3))};
            default: return {16'($signed($urandom_range(0, 20)) - 10), 16'($urandom())};
        endcase
    endfunction

    // Valid stays high between back-to-back transactions and drops only
    // for a gap, so it is never written twice in one time step.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            coord_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        coord_valid <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        do
            @(posedge clk);
        while (!coord_ready);
        @(negedge clk);
    endtask

    // Result side stalls at random, with stretches of constant readiness.
    always @(negedge clk)
    begin
        if (quiet_sink || $urandom_range(0, 99) < 30)
            noise_ready <= 1'b1;
        else
            noise_ready <= ($urandom_range(0, 9) < 4) ? 1'b0 : 1'b1;
    end

    always @(posedge clk)
    begin
        if ((coord_valid && coord_ready) || (noise_valid && noise_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** perlin_noise_3d: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] edges[8];
        int wait_cycles;
        edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_FFFF, 32'h00FF_0000, 32'hFFFF_0000, 32'h0100_8000};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Directed points: extreme coordinates, cell wrap and hash wrap.
        for (int i = 0; i < 8; i++)
            send_point(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
        send_point(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
        send_point(32'h0100_0000, 32'h0200_0000, 32'hFF00_0000);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        for (int i = 0; i < 700; i++)
        begin
            if (i == 300)
                quiet_sink = 1'b1;
            if (i == 450)
                quiet_sink = 1'b0;
            send_point(rand_coord(), rand_coord(), rand_coord());
        end
        coord_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** perlin_noise_3d: PASSED **");
        else
            $display("** perlin_noise_3d: FAILED **");
        $finish;
    end
endmodule
